@@ rtl/fed_pkg.sv @@
// ----------------------------------------------------------------------------
// fed_pkg
// Shared constants and register codes for the erosion and downsample filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fed_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_ROWS      = 2048;
  localparam int MIN_DIM       = 3;

  localparam int PIX_W     = 16;
  localparam int WGT_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int BA_W      = 10;
  localparam int ROW_W     = 11;
  localparam int BLK_W     = 17;
  localparam int NUM_WGT   = 4;
  localparam int NUM_NB    = 9;
  localparam int RANK_W    = 4;
  localparam int FRAC_W    = 12;
  localparam int PROD_W    = PIX_W + WGT_W;
  localparam int ACC_W     = PROD_W + 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);
  localparam logic [PIX_W-1:0] PIX_MAX    = 16'hFFFF;
  localparam logic [BLK_W-1:0] BLK_MAX    = 17'h1FFFF;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST     = 12'd18;
  localparam logic [CFG_W-1:0] ROW_TOTAL_RST     = 12'd18;
  localparam logic [BA_W-1:0]  BLOCKS_ACROSS_RST = 10'd8;
  localparam logic [WGT_W-1:0] WEIGHT_FIRST_RST  = 12'd512;
  localparam logic [WGT_W-1:0] WEIGHT_SECOND_RST = 12'd307;
  localparam logic [WGT_W-1:0] WEIGHT_THIRD_RST  = 12'd246;
  localparam logic [WGT_W-1:0] WEIGHT_FOURTH_RST = 12'd205;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH     = 3'd0,
    REG_ROW_TOTAL     = 3'd1,
    REG_BLOCKS_ACROSS = 3'd2,
    REG_WEIGHT_FIRST  = 3'd3,
    REG_WEIGHT_SECOND = 3'd4,
    REG_WEIGHT_THIRD  = 3'd5,
    REG_WEIGHT_FOURTH = 3'd6
  } reg_index_t;

endpackage

`default_nettype wire

@@ rtl/fuzzy_erosion_downsample.sv @@
// ----------------------------------------------------------------------------
// fuzzy_erosion_downsample
// 3x3 weighted rank-order erosion of a padded Q8.8 image, summed per 2x2 cell.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while in_tready is high and returns
// one block value per 2x2 cell of eroded interior pixels once stage four closes
// the cell. Two line memories of MAX_WIDTH x 16 bits hold the previous rows and
// a memory of MAX_WIDTH/2 x 16 bits holds the even-row pair sums; all are read
// before they are written, so no clearing pass follows reset. The pipeline runs
// rank selection, weighting, rounding and cell accumulation in separate stages;
// in_tready falls only while the output register holds a value not yet taken.
// Write configuration only while the pipeline is empty.
`default_nettype none

module fuzzy_erosion_downsample #(
  parameter int MAX_WIDTH = fed_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [fed_pkg::IN_TDATA_W-1:0]       in_tdata,   // [15:0] pixel
  input  wire logic                                 in_tuser,   // frame_start
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [fed_pkg::OUT_TDATA_W-1:0]           out_tdata,  // [16:0] block_value
  output logic                                      out_tlast,  // frame_last
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [fed_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [fed_pkg::CFG_W-1:0]            cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int PD = MAX_WIDTH / 2;
  localparam int PW = $clog2(PD);
  localparam int PIX_W = fed_pkg::PIX_W;

  typedef struct packed {
    logic          comp;
    logic          c_odd;
    logic          y_odd;
    logic          emit;
    logic          last;
    logic [PW-1:0] bx;
  } stage_ctl_t;

  function automatic logic [CW-1:0] clamp_cols(logic [fed_pkg::CFG_W-1:0] v);
    int unsigned t;
    t = 32'(v);
    if (t < fed_pkg::MIN_DIM) t = fed_pkg::MIN_DIM;
    else if (t > MAX_WIDTH) t = MAX_WIDTH;
    return t[CW-1:0];
  endfunction

  function automatic logic [fed_pkg::CFG_W-1:0] clamp_rows(logic [fed_pkg::CFG_W-1:0] v);
    int unsigned t;
    t = 32'(v);
    if (t < fed_pkg::MIN_DIM) t = fed_pkg::MIN_DIM;
    else if (t > fed_pkg::MAX_ROWS) t = fed_pkg::MAX_ROWS;
    return t[fed_pkg::CFG_W-1:0];
  endfunction

  // configuration
  logic [CW-1:0]                 width_r;
  logic [fed_pkg::CFG_W-1:0]     total_r;
  logic [fed_pkg::BA_W-1:0]      ba_r;
  logic [fed_pkg::WGT_W-1:0]     wgt_r [fed_pkg::NUM_WGT];

  // stream control
  logic adv;
  logic in_acc;

  // counters
  logic [AW-1:0]             col_r, col_nxt, c_in;
  logic [fed_pkg::ROW_W-1:0] row_r, row_nxt, r_in;
  logic [CW-1:0]             col_inc;
  logic [fed_pkg::CFG_W-1:0] row_inc;
  logic [AW-1:0]             x_v;
  logic [CW-1:0]             half_w;
  int unsigned               nblk;
  stage_ctl_t                ctl_in;

  // stage 1: line memories and window
  logic [PIX_W-1:0] line_one_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_mem [MAX_WIDTH];
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [AW-1:0]    s1_col_r;
  stage_ctl_t       s1_ctl_r;
  logic [PIX_W-1:0] top_q_r, mid_q_r, byp_top_r, byp_mid_r;
  logic             byp_r;
  logic [PIX_W-1:0] s1_top, s1_mid;
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] nb [fed_pkg::NUM_NB];
  logic [PIX_W-1:0] m_nxt [fed_pkg::NUM_WGT];
  logic [fed_pkg::RANK_W-1:0] rank;

  // stage 2: four smallest
  logic             s2_v_r;
  stage_ctl_t       s2_ctl_r;
  logic [PIX_W-1:0] m_r [fed_pkg::NUM_WGT];

  // stage 3: weighted products
  logic                        s3_v_r;
  stage_ctl_t                  s3_ctl_r;
  logic [fed_pkg::PROD_W-1:0]  prod_r [fed_pkg::NUM_WGT];
  logic [fed_pkg::ACC_W-1:0]   acc;
  logic [fed_pkg::ACC_W-fed_pkg::FRAC_W-1:0] acc_sh;
  logic [PIX_W-1:0]            e_nxt;

  // stage 4: cell accumulation
  logic [PIX_W-1:0] pair_mem [PD];
  logic             s4_v_r;
  stage_ctl_t       s4_ctl_r;
  logic [PIX_W-1:0] e_r;
  logic [PIX_W-1:0] pair_q_r;
  logic [PIX_W-1:0] pend_r;
  logic [PIX_W:0]   pair_sum;
  logic [PIX_W-1:0] pair_sat;
  logic [PIX_W+1:0] blk_sum;
  logic [fed_pkg::BLK_W-1:0] blk_sat;
  logic             s4_act;

  // output
  logic                      out_v_r;
  logic [fed_pkg::BLK_W-1:0] out_blk_r;
  logic                      out_last_r;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= clamp_cols(fed_pkg::ROW_WIDTH_RST);
      total_r <= clamp_rows(fed_pkg::ROW_TOTAL_RST);
      ba_r    <= fed_pkg::BLOCKS_ACROSS_RST;
      wgt_r[0] <= fed_pkg::WEIGHT_FIRST_RST;
      wgt_r[1] <= fed_pkg::WEIGHT_SECOND_RST;
      wgt_r[2] <= fed_pkg::WEIGHT_THIRD_RST;
      wgt_r[3] <= fed_pkg::WEIGHT_FOURTH_RST;
    end else if (cfg_valid) begin
      unique case (fed_pkg::reg_index_t'(cfg_index))
        fed_pkg::REG_ROW_WIDTH:     width_r  <= clamp_cols(cfg_data);
        fed_pkg::REG_ROW_TOTAL:     total_r  <= clamp_rows(cfg_data);
        fed_pkg::REG_BLOCKS_ACROSS: ba_r     <= cfg_data[fed_pkg::BA_W-1:0];
        fed_pkg::REG_WEIGHT_FIRST:  wgt_r[0] <= cfg_data;
        fed_pkg::REG_WEIGHT_SECOND: wgt_r[1] <= cfg_data;
        fed_pkg::REG_WEIGHT_THIRD:  wgt_r[2] <= cfg_data;
        fed_pkg::REG_WEIGHT_FOURTH: wgt_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // position of the incoming pixel and the decisions that follow from it
  always_comb begin
    c_in = in_tuser ? '0 : col_r;
    if ({1'b0, c_in} >= width_r) c_in = '0;
    r_in = in_tuser ? '0 : row_r;
    if ({1'b0, r_in} >= total_r) r_in = '0;

    col_inc = {1'b0, c_in} + CW'(1);
    row_inc = {1'b0, r_in} + fed_pkg::CFG_W'(1);
    if (col_inc >= width_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= total_r) ? '0 : row_inc[fed_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[AW-1:0];
      row_nxt = r_in;
    end

    x_v    = c_in - AW'(2);
    half_w = (width_r - CW'(2)) >> 1;
    nblk   = (32'(ba_r) < 32'(half_w)) ? 32'(ba_r) : 32'(half_w);

    ctl_in.comp  = (r_in >= fed_pkg::ROW_W'(2)) && (c_in >= AW'(2));
    ctl_in.c_odd = c_in[0];
    ctl_in.y_odd = r_in[0];
    ctl_in.bx    = PW'(x_v[AW-1:1]);
    ctl_in.emit  = 32'(ctl_in.bx) < 32'(ba_r);
    ctl_in.last  = ({1'b0, r_in} >= (total_r - fed_pkg::CFG_W'(2)))
                   && ((32'(ctl_in.bx) + 32'd1) == nblk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line memories: read at the new column, write back the previous pixel
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_v_r) begin
        line_one_mem[s1_col_r] <= s1_pix_r;
        line_two_mem[s1_col_r] <= s1_mid;
      end
      top_q_r   <= line_two_mem[c_in];
      mid_q_r   <= line_one_mem[c_in];
      byp_r     <= s1_v_r && (s1_col_r == c_in);
      byp_top_r <= s1_mid;
      byp_mid_r <= s1_pix_r;
      s1_pix_r  <= in_tdata[PIX_W-1:0];
      s1_col_r  <= c_in;
      s1_ctl_r  <= ctl_in;
    end
  end

  assign s1_top = byp_r ? byp_top_r : top_q_r;
  assign s1_mid = byp_r ? byp_mid_r : mid_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (adv && s1_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= s1_top;
      win_r[4] <= s1_mid;
      win_r[5] <= s1_pix_r;
    end
  end

  // rank every sample (ties broken by position) and pick ranks zero to three
  always_comb begin
    nb[0] = win_r[0];
    nb[1] = win_r[1];
    nb[2] = win_r[2];
    nb[3] = win_r[3];
    nb[4] = win_r[4];
    nb[5] = win_r[5];
    nb[6] = s1_top;
    nb[7] = s1_mid;
    nb[8] = s1_pix_r;
    for (int k = 0; k < fed_pkg::NUM_WGT; k++) m_nxt[k] = '0;
    rank = '0;
    for (int i = 0; i < fed_pkg::NUM_NB; i++) begin
      rank = '0;
      for (int j = 0; j < fed_pkg::NUM_NB; j++) begin
        if (j != i) begin
          if ((nb[j] < nb[i]) || ((nb[j] == nb[i]) && (j < i))) begin
            rank = rank + fed_pkg::RANK_W'(1);
          end
        end
      end
      for (int k = 0; k < fed_pkg::NUM_WGT; k++) begin
        if (rank == fed_pkg::RANK_W'(k)) m_nxt[k] = nb[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r <= s1_ctl_r;
      for (int k = 0; k < fed_pkg::NUM_WGT; k++) m_r[k] <= m_nxt[k];
      s3_ctl_r <= s2_ctl_r;
      for (int k = 0; k < fed_pkg::NUM_WGT; k++) begin
        prod_r[k] <= {{fed_pkg::WGT_W{1'b0}}, m_r[k]} * {{PIX_W{1'b0}}, wgt_r[k]};
      end
      s4_ctl_r <= s3_ctl_r;
      e_r      <= e_nxt;
      pair_q_r <= pair_mem[s3_ctl_r.bx];
    end
  end

  // round to Q8.8 and saturate
  always_comb begin
    acc = fed_pkg::ACC_W'(prod_r[0]) + fed_pkg::ACC_W'(prod_r[1])
        + fed_pkg::ACC_W'(prod_r[2]) + fed_pkg::ACC_W'(prod_r[3])
        + fed_pkg::ROUND_HALF;
    acc_sh = acc[fed_pkg::ACC_W-1:fed_pkg::FRAC_W];
    e_nxt  = (acc_sh > {2'b00, fed_pkg::PIX_MAX}) ? fed_pkg::PIX_MAX : acc_sh[PIX_W-1:0];
  end

  // combine the cell: pending even column, stored even-row pair
  always_comb begin
    pair_sum = {1'b0, pend_r} + {1'b0, e_r};
    pair_sat = pair_sum[PIX_W] ? fed_pkg::PIX_MAX : pair_sum[PIX_W-1:0];
    blk_sum  = {1'b0, pair_sum} + {2'b00, pair_q_r};
    blk_sat  = blk_sum[PIX_W+1] ? fed_pkg::BLK_MAX : blk_sum[fed_pkg::BLK_W-1:0];
    s4_act   = adv && s4_v_r && s4_ctl_r.comp;
  end

  always_ff @(posedge clk) begin
    if (s4_act && s4_ctl_r.c_odd && s4_ctl_r.emit && !s4_ctl_r.y_odd) begin
      pair_mem[s4_ctl_r.bx] <= pair_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (s4_act && !s4_ctl_r.c_odd) begin
      pend_r <= e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r && s4_ctl_r.comp && s4_ctl_r.c_odd && s4_ctl_r.emit
                 && s4_ctl_r.y_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blk_r  <= blk_sat;
      out_last_r <= s4_ctl_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(fed_pkg::OUT_TDATA_W - fed_pkg::BLK_W){1'b0}}, out_blk_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ tb/sv/fed_checker.sv @@
// ----------------------------------------------------------------------------
// fed_checker
// Scoreboard for the erosion and downsample filter.
// ----------------------------------------------------------------------------
// Watches the register, pixel and block streams. Keeps its own copy of the
// registers, line memories and pair sums and computes each block value from the
// pixel beats. Every block beat is compared field by field with the oldest
// predicted block. The count of predicted blocks still in flight and the count
// of mismatches go back to the test top.
module fed_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [fed_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tuser,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [fed_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                             out_tlast,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [fed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fed_pkg::CFG_W-1:0]        cfg_data,
  output int unsigned                           pending_blocks,
  output int unsigned                           mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import fed_pkg::*;

  localparam int PAIR_DEPTH = MAX_WIDTH_DEF / 2;

  typedef struct packed {
    bit [BLK_W-1:0] block_value;
    bit             frame_last;
  } block_beat_t;

  bit [CFG_W-1:0]                width_reg;
  bit [CFG_W-1:0]                total_reg;
  bit [BA_W-1:0]                 blocks_reg;
  bit [NUM_WGT-1:0][WGT_W-1:0]   rank_weight;

  bit [PIX_W-1:0]                line_up     [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]                line_two_up [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]                pair_mem    [PAIR_DEPTH];
  bit [5:0][PIX_W-1:0]           window_cols;
  bit [ROW_W-1:0]                col_pos;
  bit [ROW_W-1:0]                row_pos;
  bit [PIX_W-1:0]                held_eroded;

  block_beat_t                   expected_blocks[$];
  int unsigned                   block_count;

  initial begin
    mismatch_count = 0;
    pending_blocks = 0;
    block_count    = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH block %0d %s: got %0d, predicted %0d", block_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic bit [PIX_W-1:0] erode_value(input bit [NUM_NB-1:0][PIX_W-1:0] nb);
    bit [PIX_W-1:0] tmp;
    bit [63:0]      acc;
    acc = 64'd2048;
    for (int i = 0; i < NUM_WGT; i++) begin
      for (int j = i + 1; j < NUM_NB; j++) begin
        if (nb[j] < nb[i]) begin
          tmp   = nb[i];
          nb[i] = nb[j];
          nb[j] = tmp;
        end
      end
      acc += 64'(rank_weight[i]) * 64'(nb[i]);
    end
    acc = acc >> FRAC_W;
    return (acc > 64'(PIX_MAX)) ? PIX_MAX : acc[PIX_W-1:0];
  endfunction

  task automatic take_pixel(input bit [PIX_W-1:0] pix, input bit frame_start);
    int unsigned              w, h, c, r, x, y, bx, nblk, pair, sum;
    bit [PIX_W-1:0]           top_px, mid_px, eroded;
    bit [NUM_NB-1:0][PIX_W-1:0] nb;
    block_beat_t              beat;
    w = (width_reg < MIN_DIM) ? MIN_DIM :
        (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    h = (total_reg < MIN_DIM) ? MIN_DIM :
        (total_reg > MAX_ROWS) ? MAX_ROWS : total_reg;
    if (frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    top_px = line_two_up[c];
    mid_px = line_up[c];
    if (r >= 2 && c >= 2) begin
      x = c - 2;
      y = r - 2;
      nb = {pix, mid_px, top_px, window_cols};
      eroded = erode_value(nb);
      bx = x >> 1;
      if ((x & 1) == 0) begin
        held_eroded = eroded;
      end else if (bx < blocks_reg && bx < PAIR_DEPTH) begin
        pair = held_eroded + eroded;
        if ((y & 1) == 0) begin
          pair_mem[bx] = (pair > PIX_MAX) ? PIX_MAX : pair[PIX_W-1:0];
        end else begin
          sum  = pair + pair_mem[bx];
          nblk = (blocks_reg < ((w - 2) >> 1)) ? blocks_reg : ((w - 2) >> 1);
          beat.block_value = (sum > BLK_MAX) ? BLK_MAX : sum[BLK_W-1:0];
          beat.frame_last  = (y + 2 >= h - 2) && (bx + 1 == nblk);
          expected_blocks.push_back(beat);
        end
      end
    end
    window_cols    = {pix, mid_px, top_px, window_cols[5:3]};
    line_two_up[c] = mid_px;
    line_up[c]     = pix;
    c = c + 1;
    if (c >= w) begin
      c = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    col_pos = c[ROW_W-1:0];
    row_pos = r[ROW_W-1:0];
  endtask

  task automatic check_block(input bit [BLK_W-1:0] value, input bit last);
    block_beat_t want;
    block_count++;
    if (expected_blocks.size() == 0) begin
      report_mismatch("unpredicted block_value", value, 0);
    end else begin
      want = expected_blocks.pop_front();
      if (value != want.block_value) report_mismatch("block_value", value, want.block_value);
      if (last != want.frame_last) report_mismatch("frame_last", last, want.frame_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg   = ROW_WIDTH_RST;
      total_reg   = ROW_TOTAL_RST;
      blocks_reg  = BLOCKS_ACROSS_RST;
      rank_weight = {WEIGHT_FOURTH_RST, WEIGHT_THIRD_RST, WEIGHT_SECOND_RST,
                     WEIGHT_FIRST_RST};
      window_cols = '0;
      col_pos     = '0;
      row_pos     = '0;
      held_eroded = '0;
      expected_blocks.delete();
    end else begin
      if (out_tvalid && out_tready) check_block(out_tdata[BLK_W-1:0], out_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH:     width_reg      = cfg_data;
          REG_ROW_TOTAL:     total_reg      = cfg_data;
          REG_BLOCKS_ACROSS: blocks_reg     = cfg_data[BA_W-1:0];
          REG_WEIGHT_FIRST:  rank_weight[0] = cfg_data;
          REG_WEIGHT_SECOND: rank_weight[1] = cfg_data;
          REG_WEIGHT_THIRD:  rank_weight[2] = cfg_data;
          REG_WEIGHT_FOURTH: rank_weight[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata[PIX_W-1:0], in_tuser);
    end
    pending_blocks = expected_blocks.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the erosion and downsample filter.
// ----------------------------------------------------------------------------
// Streams padded frames into the filter under changing geometry and weights:
// a frame at reset settings, two directed frames for saturation and the
// smallest geometry, then random frames with random content, truncated frames,
// frames that rely on counter wrap, and the largest row width and row count.
// Sender and receiver idle at random, and once the receiver holds off for a
// long stretch. The checker predicts and compares every block beat.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fed_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum {FILL_RANDOM, FILL_EXTREMES, FILL_TIES, FILL_MAX} fill_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  int unsigned             pending_blocks;
  int unsigned             mismatch_count;
  int unsigned             send_idle_pct;
  int unsigned             recv_idle_pct;
  int unsigned             hold_off_req;
  int unsigned             cycle_count;

  fuzzy_erosion_downsample u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fed_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending_blocks (pending_blocks),
    .mismatch_count (mismatch_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fuzzy_erosion_downsample verification failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_req) @(negedge clk);
        hold_off_req = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int clamp_dim(input bit [CFG_W-1:0] value, input int top_limit);
    return (value < MIN_DIM) ? MIN_DIM : (value > top_limit) ? top_limit : int'(value);
  endfunction

  function automatic bit [WGT_W-1:0] pick_weight();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return WGT_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic bit [PIX_W-1:0] pick_pixel(input fill_t fill);
    case (fill)
      FILL_EXTREMES: return $urandom_range(1) ? PIX_MAX : '0;
      FILL_TIES:     return 16'h7FF0 + PIX_W'($urandom_range(3));
      FILL_MAX:      return PIX_MAX;
      default:       return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input bit [PIX_W-1:0] pix, input bit frame_start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= frame_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold until every predicted block is out, then let the pipeline empty
  task automatic drain_blocks();
    in_tvalid <= 1'b0;
    while (pending_blocks != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input int cols, input int rows, input bit mark_start,
                            input int cut_at);
    fill_t fill;
    case ($urandom_range(5))
      0:       fill = FILL_EXTREMES;
      1:       fill = FILL_TIES;
      2:       fill = FILL_MAX;
      default: fill = FILL_RANDOM;
    endcase
    for (int i = 0; i < cols * rows && i != cut_at; i++) begin
      send_pixel(pick_pixel(fill), mark_start && i == 0);
    end
  endtask

  task automatic run_phase(input bit [CFG_W-1:0] width, input bit [CFG_W-1:0] total,
                           input bit [CFG_W-1:0] blocks,
                           input bit [NUM_WGT-1:0][WGT_W-1:0] wgt,
                           input int frames, input bit noisy, input int unsigned hold_len);
    int cols, rows, cut;
    bit whole;
    drain_blocks();
    write_reg(REG_ROW_WIDTH, width);
    write_reg(REG_ROW_TOTAL, total);
    write_reg(REG_BLOCKS_ACROSS, blocks);
    write_reg(REG_WEIGHT_FIRST, wgt[0]);
    write_reg(REG_WEIGHT_SECOND, wgt[1]);
    write_reg(REG_WEIGHT_THIRD, wgt[2]);
    write_reg(REG_WEIGHT_FOURTH, wgt[3]);
    cfg_valid <= 1'b0;
    if (hold_len != 0) hold_off_req <= hold_len;
    cols  = clamp_dim(width, MAX_WIDTH_DEF);
    rows  = clamp_dim(total, MAX_ROWS);
    whole = 1'b0;
    for (int f = 0; f < frames; f++) begin
      cut = (noisy && $urandom_range(5) == 0) ? $urandom_range(1, cols * rows - 1) : -1;
      send_frame(cols, rows, !whole || !noisy || ($urandom_range(3) != 0), cut);
      whole = (cut < 0);
    end
  endtask

  task automatic random_phase();
    bit [CFG_W-1:0]              width, total, blocks;
    bit [NUM_WGT-1:0][WGT_W-1:0] wgt;
    int                          inner;
    width  = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 16));
    total  = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 10));
    inner  = (width < MIN_DIM) ? 1 : int'(width) - 2;
    blocks = ($urandom_range(9) == 0) ? '0 : CFG_W'($urandom_range(1, inner / 2 + 1));
    blocks[CFG_W-1:BA_W] = $urandom_range(3);
    for (int i = 0; i < NUM_WGT; i++) wgt[i] = pick_weight();
    run_phase(width, total, blocks, wgt, 2, 1'b1, 0);
  endtask

  initial begin
    bit [NUM_WGT-1:0][WGT_W-1:0] wgt;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ROW_WIDTH;
    cfg_data      = '0;
    send_idle_pct = 6;
    recv_idle_pct = 76;
    hold_off_req  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_frame(ROW_WIDTH_RST, ROW_TOTAL_RST, 1'b1, -1);

    // saturate every sum on the smallest frame with one block
    drain_blocks();
    write_reg(REG_SPARE, '1);
    write_reg(REG_ROW_WIDTH, 12'd4);
    write_reg(REG_ROW_TOTAL, 12'd4);
    write_reg(REG_BLOCKS_ACROSS, 12'd1023);
    write_reg(REG_WEIGHT_FIRST, '1);
    write_reg(REG_WEIGHT_SECOND, '1);
    write_reg(REG_WEIGHT_THIRD, '1);
    write_reg(REG_WEIGHT_FOURTH, '1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 16; i++) send_pixel(PIX_MAX, i == 0);

    // clamp geometry up to 3x3: one interior pixel, no partner, no block
    drain_blocks();
    write_reg(REG_ROW_WIDTH, '0);
    write_reg(REG_ROW_TOTAL, '0);
    write_reg(REG_WEIGHT_FIRST, '0);
    write_reg(REG_WEIGHT_SECOND, '0);
    write_reg(REG_WEIGHT_THIRD, '0);
    write_reg(REG_WEIGHT_FOURTH, '0);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_pixel((i % 2 == 1) ? PIX_MAX : '0, i == 0);

    repeat (3) random_phase();

    send_idle_pct = 76;
    recv_idle_pct <= 6;
    repeat (2) random_phase();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(12'd18, 12'd8, 12'd8,
              {WEIGHT_FOURTH_RST, WEIGHT_THIRD_RST, WEIGHT_SECOND_RST, WEIGHT_FIRST_RST},
              1, 1'b0, 400);
    random_phase();
    for (int i = 0; i < NUM_WGT; i++) wgt[i] = pick_weight();
    run_phase(12'd12, 12'd6, '0, wgt, 2, 1'b1, 0);
    for (int i = 0; i < NUM_WGT; i++) wgt[i] = pick_weight();
    run_phase('1, 12'd4, 12'd1023, wgt, 1, 1'b0, 0);
    for (int i = 0; i < NUM_WGT; i++) wgt[i] = pick_weight();
    run_phase(12'd4, '1, 12'd1023, wgt, 1, 1'b0, 0);

    drain_blocks();
    if (mismatch_count == 0 && pending_blocks == 0) begin
      $display("fuzzy_erosion_downsample verification clean");
    end else begin
      $display("fuzzy_erosion_downsample verification failed");
    end
    $finish;
  end

endmodule
